[sv/gbts_pkg.sv]
// Shared types and constants for the gap-buffer text search block.
`default_nettype none

package gbts_pkg;

  // Store geometry
  localparam int CAPACITY    = 4096;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int POS_W       = 13;
  localparam int PATTERN_MAX = 8;
  localparam int PLEN_W      = 4;
  localparam int PAT_W       = 8 * PATTERN_MAX;

  localparam logic [POS_W-1:0] CAP_POS      = POS_W'(CAPACITY);
  localparam logic [7:0]       NEWLINE_BYTE = 8'h0A;

  // Configuration register indexes
  localparam logic CFG_GAP_FIRST = 1'b0;
  localparam logic CFG_GAP_PAST  = 1'b1;

  // Request commands
  typedef enum logic [2:0] {
    CMD_WRITE        = 3'd0,
    CMD_FIND_BYTE    = 3'd1,
    CMD_FIND_PATTERN = 3'd2,
    CMD_LINE_START   = 3'd3,
    CMD_LINE_END     = 3'd4,
    CMD_LINE_COUNT   = 3'd5,
    CMD_LINE_NUMBER  = 3'd6,
    CMD_NONE         = 3'd7
  } cmd_t;

  // Scan engine sequencer states
  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_HOLD
  } eng_state_t;

  // Request payload
  typedef struct packed {
    cmd_t                command;
    logic [POS_W-1:0]    position;
    logic [7:0]          byte_value;
    logic [PAT_W-1:0]    pattern;
    logic [PLEN_W-1:0]   pattern_length;
  } req_t;

  // Result payload
  typedef struct packed {
    logic                found;
    logic [POS_W-1:0]    result_value;
  } rslt_t;

  // Gap geometry after clamping
  typedef struct packed {
    logic [POS_W-1:0]    lo;
    logic [POS_W-1:0]    gsize;
    logic [POS_W-1:0]    length;
  } gap_t;

  // Engine status toward the top level
  typedef struct packed {
    logic                ready;
    logic                res_valid;
  } eng_stat_t;

endpackage

`default_nettype wire

[sv/gbts_engine.sv]
// Text store and scan sequencer: one store read and one byte compare per cycle while a scan runs.
`default_nettype none

module gbts_engine (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire gbts_pkg::req_t     req,
  input  wire gbts_pkg::gap_t     gap,
  input  wire logic               take,
  output gbts_pkg::eng_stat_t     stat,
  output gbts_pkg::rslt_t         res
);

  localparam int POS_W = gbts_pkg::POS_W;
  localparam int PAT_W = gbts_pkg::PAT_W;
  localparam int PM    = gbts_pkg::PATTERN_MAX;

  // Text store
  logic [7:0] mem [gbts_pkg::CAPACITY];
  logic [7:0] rdata;
  logic                        mem_we;
  logic [gbts_pkg::ADDR_W-1:0] wr_addr;
  logic                        rd_en;
  logic [gbts_pkg::ADDR_W-1:0] rd_addr;

  // Sequencer registers
  gbts_pkg::eng_state_t state, state_next;
  gbts_pkg::cmd_t       cmd, cmd_next;
  logic [7:0]           bval, bval_next;
  logic [PAT_W-1:0]     pat_al, pat_al_next;
  logic [PM-1:0]        pmask, pmask_next;
  logic [gbts_pkg::PLEN_W-1:0] plen, plen_next;
  logic [gbts_pkg::PLEN_W-1:0] fill, fill_next;
  logic [PAT_W-1:0]     window, window_next;
  logic [POS_W-1:0]     ip, ip_next;
  logic [POS_W-1:0]     last, last_next;
  logic                 dir_up, dir_up_next;
  logic                 issue_on, issue_on_next;
  logic                 dv, dv_next;
  logic [POS_W-1:0]     dq, dq_next;
  logic                 dlast, dlast_next;
  logic [POS_W-1:0]     count, count_next;
  gbts_pkg::rslt_t      res_r, res_next;

  always_comb begin
    logic [POS_W-1:0]   len;
    logic [POS_W-1:0]   pos;
    logic               pos_in;
    logic [POS_W-1:0]   cp;
    logic [POS_W:0]     pat_end;
    logic [gbts_pkg::PLEN_W-1:0] sh;
    logic [POS_W-1:0]   phys;
    logic [7:0]         target;
    logic               eq;
    logic [PAT_W-1:0]   win_new;
    logic [PM-1:0]      byte_ok;
    logic               match;
    logic [gbts_pkg::PLEN_W-1:0] fill_inc;
    logic [POS_W-1:0]   cnt_inc;
    logic               fin;
    gbts_pkg::rslt_t    fin_res;

    len     = gap.length;
    pos     = req.position;
    pos_in  = pos < len;
    cp      = pos_in ? pos : ((len != '0) ? len - POS_W'(1) : '0);
    pat_end = {1'b0, pos} + (POS_W+1)'(req.pattern_length);
    sh      = gbts_pkg::PLEN_W'(PM) - req.pattern_length;

    // Logical to physical mapping past the gap
    phys    = (ip < gap.lo) ? ip : ip + gap.gsize;

    // Shared byte compare: target byte or line break
    target  = (cmd == gbts_pkg::CMD_FIND_BYTE) ? bval : gbts_pkg::NEWLINE_BYTE;
    eq      = (rdata == target);

    // Pattern window: newest byte at the top
    win_new = {rdata, window[PAT_W-1:8]};
    for (int k = 0; k < PM; k++) begin
      byte_ok[k] = !pmask[k] || (win_new[8*k +: 8] == pat_al[8*k +: 8]);
    end
    match    = &byte_ok;
    fill_inc = (fill == gbts_pkg::PLEN_W'(PM)) ? fill : fill + gbts_pkg::PLEN_W'(1);
    cnt_inc  = count + POS_W'(eq);

    state_next    = state;
    cmd_next      = cmd;
    bval_next     = bval;
    pat_al_next   = pat_al;
    pmask_next    = pmask;
    plen_next     = plen;
    fill_next     = fill;
    window_next   = window;
    ip_next       = ip;
    last_next     = last;
    dir_up_next   = dir_up;
    issue_on_next = issue_on;
    dv_next       = 1'b0;
    dq_next       = dq;
    dlast_next    = dlast;
    count_next    = count;
    res_next      = res_r;
    mem_we        = 1'b0;
    wr_addr       = pos[gbts_pkg::ADDR_W-1:0];
    rd_en         = 1'b0;
    rd_addr       = phys[gbts_pkg::ADDR_W-1:0];
    fin           = 1'b0;
    fin_res       = '0;

    unique case (state)
      gbts_pkg::ENG_IDLE: begin
        if (start) begin
          // Latch the request and set up the scan range
          cmd_next      = req.command;
          bval_next     = req.byte_value;
          plen_next     = req.pattern_length;
          pat_al_next   = req.pattern << {sh[2:0], 3'b000};
          pmask_next    = ~(PM'({PM{1'b1}}) >> req.pattern_length);
          fill_next     = '0;
          count_next    = '0;
          issue_on_next = 1'b1;
          dir_up_next   = 1'b1;
          state_next    = gbts_pkg::ENG_SCAN;
          unique case (req.command)
            gbts_pkg::CMD_WRITE: begin
              mem_we        = (pos < gbts_pkg::CAP_POS);
              issue_on_next = 1'b0;
              state_next    = gbts_pkg::ENG_IDLE;
            end
            gbts_pkg::CMD_FIND_BYTE: begin
              ip_next   = pos;
              last_next = len - POS_W'(1);
              if (!pos_in) begin
                fin = 1'b1;
              end
            end
            gbts_pkg::CMD_FIND_PATTERN: begin
              ip_next   = pos;
              last_next = len - POS_W'(1);
              if (req.pattern_length == '0 ||
                  req.pattern_length > gbts_pkg::PLEN_W'(PM) ||
                  !pos_in || pat_end > {1'b0, len}) begin
                fin = 1'b1;
              end
            end
            gbts_pkg::CMD_LINE_START: begin
              ip_next     = cp - POS_W'(1);
              last_next   = '0;
              dir_up_next = 1'b0;
              if (cp == '0) begin
                fin           = 1'b1;
                fin_res.found = 1'b1;
              end
            end
            gbts_pkg::CMD_LINE_END: begin
              ip_next   = pos;
              last_next = len - POS_W'(1);
              if (!pos_in) begin
                fin                  = 1'b1;
                fin_res.found        = 1'b1;
                fin_res.result_value = len;
              end
            end
            gbts_pkg::CMD_LINE_COUNT: begin
              ip_next   = '0;
              last_next = len - POS_W'(1);
              if (len == '0) begin
                fin           = 1'b1;
                fin_res.found = 1'b1;
              end
            end
            gbts_pkg::CMD_LINE_NUMBER: begin
              ip_next   = '0;
              last_next = cp - POS_W'(1);
              if (cp == '0) begin
                fin           = 1'b1;
                fin_res.found = 1'b1;
              end
            end
            gbts_pkg::CMD_NONE: begin
              issue_on_next = 1'b0;
              state_next    = gbts_pkg::ENG_IDLE;
            end
          endcase
        end
      end

      gbts_pkg::ENG_SCAN: begin
        // Issue the next store read
        if (issue_on) begin
          rd_en      = 1'b1;
          dv_next    = 1'b1;
          dq_next    = ip;
          dlast_next = (ip == last);
          if (ip == last) begin
            issue_on_next = 1'b0;
          end else begin
            ip_next = dir_up ? ip + POS_W'(1) : ip - POS_W'(1);
          end
        end
        // Examine the byte read in the previous cycle
        if (dv) begin
          unique case (cmd)
            gbts_pkg::CMD_FIND_BYTE: begin
              if (eq) begin
                fin                  = 1'b1;
                fin_res.found        = 1'b1;
                fin_res.result_value = dq;
              end else if (dlast) begin
                fin = 1'b1;
              end
            end
            gbts_pkg::CMD_FIND_PATTERN: begin
              window_next = win_new;
              fill_next   = fill_inc;
              if (match && fill_inc >= plen) begin
                fin                  = 1'b1;
                fin_res.found        = 1'b1;
                fin_res.result_value = dq - POS_W'(plen) + POS_W'(1);
              end else if (dlast) begin
                fin = 1'b1;
              end
            end
            gbts_pkg::CMD_LINE_START: begin
              fin_res.found = 1'b1;
              if (eq) begin
                fin                  = 1'b1;
                fin_res.result_value = dq + POS_W'(1);
              end else if (dlast) begin
                fin = 1'b1;
              end
            end
            gbts_pkg::CMD_LINE_END: begin
              fin_res.found = 1'b1;
              if (eq) begin
                fin                  = 1'b1;
                fin_res.result_value = dq;
              end else if (dlast) begin
                fin                  = 1'b1;
                fin_res.result_value = len;
              end
            end
            gbts_pkg::CMD_LINE_COUNT: begin
              count_next           = cnt_inc;
              fin_res.found        = 1'b1;
              fin_res.result_value = cnt_inc + POS_W'(1);
              fin                  = dlast;
            end
            gbts_pkg::CMD_LINE_NUMBER: begin
              count_next           = cnt_inc;
              fin_res.found        = 1'b1;
              fin_res.result_value = cnt_inc;
              fin                  = dlast;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      gbts_pkg::ENG_HOLD: begin
        // Hand the result over once the output register takes it
        if (take) begin
          state_next = gbts_pkg::ENG_IDLE;
        end
      end

      default: begin
        state_next = gbts_pkg::ENG_IDLE;
      end
    endcase

    // Finish: load the result and stop issuing
    if (fin) begin
      res_next      = fin_res;
      state_next    = gbts_pkg::ENG_HOLD;
      issue_on_next = 1'b0;
      dv_next       = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= gbts_pkg::ENG_IDLE;
      issue_on <= 1'b0;
      dv       <= 1'b0;
    end else begin
      state    <= state_next;
      issue_on <= issue_on_next;
      dv       <= dv_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd    <= cmd_next;
    bval   <= bval_next;
    pat_al <= pat_al_next;
    pmask  <= pmask_next;
    plen   <= plen_next;
    fill   <= fill_next;
    window <= window_next;
    ip     <= ip_next;
    last   <= last_next;
    dir_up <= dir_up_next;
    dq     <= dq_next;
    dlast  <= dlast_next;
    count  <= count_next;
    res_r  <= res_next;
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= req.byte_value;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  assign stat.ready     = (state == gbts_pkg::ENG_IDLE);
  assign stat.res_valid = (state == gbts_pkg::ENG_HOLD);
  assign res            = res_r;

endmodule

`default_nettype wire

[sv/gap_buffer_text_search.sv]
// Top level of the gap-buffer text search block: gap registers and result register.
//
// Requests enter on req_valid / req_stall / req; a request is taken at a rising
// edge with req_valid high and req_stall low. Results leave on rslt_valid /
// rslt_stall / rslt under the same rule. Gap registers are written through
// cfg_we / cfg_index / cfg_data (index 0 gap_first, index 1 gap_past); the user
// must write them only while idle, as the block itself does not enforce this.
// A write request stores its byte in the accepting cycle and gives no result;
// command 7 is dropped the same way. Every other command gives one result.
// Queries scan the text one byte per cycle through the single store read port;
// the next request can be taken once the result of the last one has moved
// into the output register.
// req_stall is high while a query is in progress, so one request is worked on
// at a time. A finished result waits in the output register while the next
// request is accepted; if the receiver stalls and that register is still full,
// the next result is held inside the engine until the register frees up.
// Synchronous reset returns the engine to idle, empties the output register and
// sets the gap to cover the whole store; stored text is not cleared.
`default_nettype none

module gap_buffer_text_search (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire gbts_pkg::req_t               req,
  output logic                              rslt_valid,
  input  wire logic                         rslt_stall,
  output gbts_pkg::rslt_t                   rslt,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [gbts_pkg::POS_W-1:0]   cfg_data
);

  localparam int POS_W = gbts_pkg::POS_W;

  logic [POS_W-1:0]    gap_first;
  logic [POS_W-1:0]    gap_past;
  gbts_pkg::gap_t      gap;
  gbts_pkg::eng_stat_t stat;
  gbts_pkg::rslt_t     eng_res;
  logic                start;
  logic                take;

  // Gap registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_first <= '0;
      gap_past  <= gbts_pkg::CAP_POS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gbts_pkg::CFG_GAP_FIRST: gap_first <= cfg_data;
        gbts_pkg::CFG_GAP_PAST:  gap_past  <= cfg_data;
      endcase
    end
  end

  // Clamp the gap into the store and derive the logical length
  always_comb begin
    logic [POS_W-1:0] hi_c;
    logic [POS_W-1:0] hi;
    gap.lo     = (gap_first > gbts_pkg::CAP_POS) ? gbts_pkg::CAP_POS : gap_first;
    hi_c       = (gap_past > gbts_pkg::CAP_POS) ? gbts_pkg::CAP_POS : gap_past;
    hi         = (hi_c < gap.lo) ? gap.lo : hi_c;
    gap.gsize  = hi - gap.lo;
    gap.length = gbts_pkg::CAP_POS - gap.gsize;
  end

  // Accept a request only while the engine is idle
  assign req_stall = !stat.ready;
  assign start     = req_valid && stat.ready;

  gbts_engine u_engine (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .gap   (gap),
    .take  (take),
    .stat  (stat),
    .res   (eng_res)
  );

  // Move a finished result into the output register when it is free
  assign take = stat.res_valid && (!rslt_valid || !rslt_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rslt_valid <= 1'b0;
    end else if (take) begin
      rslt_valid <= 1'b1;
    end else if (!rslt_stall) begin
      rslt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rslt <= eng_res;
    end
  end

endmodule

`default_nettype wire
